// File: src/sqltok_pkg.sv
// Shared types and constants of the SQL keyword tokenizer.
package sqltok_pkg;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_ID   = 2'd2;

    localparam logic [3:0] TOK_NUMBER    = 4'd0;
    localparam logic [3:0] TOK_IDENT     = 4'd1;
    localparam logic [3:0] TOK_SELECT    = 4'd2;
    localparam logic [3:0] TOK_CREATE    = 4'd3;
    localparam logic [3:0] TOK_FROM      = 4'd4;
    localparam logic [3:0] TOK_DROP      = 4'd5;
    localparam logic [3:0] TOK_INT       = 4'd6;
    localparam logic [3:0] TOK_OPEN      = 4'd7;
    localparam logic [3:0] TOK_CLOSE     = 4'd8;
    localparam logic [3:0] TOK_COMMA     = 4'd9;
    localparam logic [3:0] TOK_SEMICOLON = 4'd10;

    localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
    localparam logic [7:0] CH_LOWER_LO  = 8'h61;
    localparam logic [7:0] CH_LOWER_HI  = 8'h7A;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_PAREN_OPN = 8'h28;
    localparam logic [7:0] CH_PAREN_CLS = 8'h29;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;

    // Keywords packed with the first byte most significant.
    localparam logic [47:0] KW_SELECT = 48'h73656C656374;
    localparam logic [47:0] KW_CREATE = 48'h637265617465;
    localparam logic [47:0] KW_FROM   = 48'h000066726F6D;
    localparam logic [47:0] KW_DROP   = 48'h000064726F70;
    localparam logic [47:0] KW_INT    = 48'h000000696E74;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [3:0]  token_type;
        logic [11:0] token_start;
        logic [12:0] token_length;
        logic        run_last;
    } t_token;

    typedef struct packed {
        logic [1:0] num;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic [3:0] ident_type(input logic [47:0] prefix,
                                              input logic too_long);
        logic [3:0] t;
        t = TOK_IDENT;
        if (!too_long) begin
            if (prefix == KW_SELECT) t = TOK_SELECT;
            else if (prefix == KW_CREATE) t = TOK_CREATE;
            else if (prefix == KW_FROM) t = TOK_FROM;
            else if (prefix == KW_DROP) t = TOK_DROP;
            else if (prefix == KW_INT) t = TOK_INT;
        end
        return t;
    endfunction

endpackage

// File: src/sqltok_lexer.sv
// Scanner state and per-byte token decisions of the tokenizer.
module sqltok_lexer #(
    parameter int MAX_STRING_LEN = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_string,
    output sqltok_pkg::t_push    o_push
);

    localparam int PW = $clog2(MAX_STRING_LEN + 1);
    localparam int SW = $clog2(MAX_STRING_LEN);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_STRING_LEN);

    logic [1:0]    r_mode, n_mode;
    logic [PW-1:0] r_pos, n_pos;
    logic [SW-1:0] r_start, n_start;
    logic [47:0]   r_prefix, n_prefix;
    logic          r_too_long, n_too_long;

    logic [1:0]    m_mode;
    logic [SW-1:0] m_start;
    logic [47:0]   m_prefix;
    logic          m_too_long;

    logic          sat, digit, lower, idch, taken, punct;
    logic          e_old, e_single, e_eos;
    logic [3:0]    single_type;
    sqltok_pkg::t_token tok_old, tok_single, tok_eos;
    logic [PW-1:0] len_old, len_eos;

    function automatic logic [12:0] to_len(input logic [PW-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[12:0];
    endfunction

    function automatic logic [11:0] to_start(input logic [SW-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[11:0];
    endfunction

    always_comb begin
        sat   = (r_pos == POS_MAX);
        digit = (i_char_code >= sqltok_pkg::CH_DIGIT_LO) &&
                (i_char_code <= sqltok_pkg::CH_DIGIT_HI);
        lower = (i_char_code >= sqltok_pkg::CH_LOWER_LO) &&
                (i_char_code <= sqltok_pkg::CH_LOWER_HI);
        idch  = digit || lower || (i_char_code == sqltok_pkg::CH_UNDER);

        punct       = 1'b1;
        single_type = sqltok_pkg::TOK_OPEN;
        case (i_char_code)
            sqltok_pkg::CH_PAREN_OPN: single_type = sqltok_pkg::TOK_OPEN;
            sqltok_pkg::CH_PAREN_CLS: single_type = sqltok_pkg::TOK_CLOSE;
            sqltok_pkg::CH_COMMA:     single_type = sqltok_pkg::TOK_COMMA;
            sqltok_pkg::CH_SEMICOLON: single_type = sqltok_pkg::TOK_SEMICOLON;
            default:                  punct = 1'b0;
        endcase

        m_mode     = r_mode;
        m_start    = r_start;
        m_prefix   = r_prefix;
        m_too_long = r_too_long;
        taken      = 1'b0;
        e_old      = 1'b0;
        e_single   = 1'b0;

        // Bytes past the length limit leave the state alone unless they carry the end mark.
        if (!sat) begin
            if (r_mode == sqltok_pkg::MODE_NUM && digit) begin
                taken = 1'b1;
            end else if (r_mode == sqltok_pkg::MODE_ID && idch) begin
                taken = 1'b1;
                if (r_prefix[47:40] != 8'd0) m_too_long = 1'b1;
                else m_prefix = {r_prefix[39:0], i_char_code};
            end else begin
                e_old  = (r_mode == sqltok_pkg::MODE_NUM) || (r_mode == sqltok_pkg::MODE_ID);
                m_mode = sqltok_pkg::MODE_IDLE;
            end

            if (!taken) begin
                if (digit) begin
                    m_mode  = sqltok_pkg::MODE_NUM;
                    m_start = r_pos[SW-1:0];
                end else if (lower) begin
                    m_mode     = sqltok_pkg::MODE_ID;
                    m_start    = r_pos[SW-1:0];
                    m_prefix   = {40'd0, i_char_code};
                    m_too_long = 1'b0;
                end else begin
                    e_single = punct;
                end
            end
        end

        e_eos = i_end_of_string &&
                ((m_mode == sqltok_pkg::MODE_NUM) || (m_mode == sqltok_pkg::MODE_ID));

        len_old = r_pos - PW'(r_start);
        len_eos = sat ? (POS_MAX - PW'(m_start)) : (r_pos - PW'(m_start) + PW'(1));

        tok_old.token_type   = (r_mode == sqltok_pkg::MODE_NUM) ? sqltok_pkg::TOK_NUMBER :
                               sqltok_pkg::ident_type(r_prefix, r_too_long);
        tok_old.token_start  = to_start(r_start);
        tok_old.token_length = to_len(len_old);
        tok_old.run_last     = 1'b0;

        tok_single.token_type   = single_type;
        tok_single.token_start  = to_start(r_pos[SW-1:0]);
        tok_single.token_length = 13'd1;
        tok_single.run_last     = 1'b0;

        tok_eos.token_type   = (m_mode == sqltok_pkg::MODE_NUM) ? sqltok_pkg::TOK_NUMBER :
                               sqltok_pkg::ident_type(m_prefix, m_too_long);
        tok_eos.token_start  = to_start(m_start);
        tok_eos.token_length = to_len(len_eos);
        tok_eos.run_last     = 1'b0;

        o_push.num  = i_accept ? (2'(e_old) + 2'(e_single) + 2'(e_eos)) : 2'd0;
        o_push.tok0 = e_old ? tok_old : (e_single ? tok_single : tok_eos);
        o_push.tok1 = (e_old && e_single) ? tok_single : tok_eos;
        o_push.tok0.run_last = (o_push.num == 2'd1);
        o_push.tok1.run_last = 1'b1;

        if (i_end_of_string) begin
            n_mode     = sqltok_pkg::MODE_IDLE;
            n_pos      = '0;
            n_start    = '0;
            n_prefix   = '0;
            n_too_long = 1'b0;
        end else begin
            n_mode     = m_mode;
            n_pos      = sat ? r_pos : r_pos + PW'(1);
            n_start    = m_start;
            n_prefix   = m_prefix;
            n_too_long = m_too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= sqltok_pkg::MODE_IDLE;
            r_pos      <= '0;
            r_start    <= '0;
            r_prefix   <= '0;
            r_too_long <= 1'b0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_start    <= n_start;
            r_prefix   <= n_prefix;
            r_too_long <= n_too_long;
        end
    end

endmodule

// File: src/sqltok_fifo.sv
// Four-entry result queue that takes up to two tokens per cycle.
module sqltok_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sqltok_pkg::t_push  i_push,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output sqltok_pkg::t_token o_token
);

    sqltok_pkg::t_token r_mem [sqltok_pkg::FIFO_DEPTH];
    logic [sqltok_pkg::FIFO_AW-1:0] r_wptr, r_rptr;
    logic [sqltok_pkg::FIFO_CW-1:0] r_count;
    logic pop;

    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rptr];
    assign pop     = o_valid && i_ready;
    // Room for two results is needed before an item may be taken.
    assign o_space = (r_count <= sqltok_pkg::FIFO_CW'(sqltok_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) r_mem[r_wptr] <= i_push.tok0;
        if (i_push.num == 2'd2) r_mem[r_wptr + sqltok_pkg::FIFO_AW'(1)] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + sqltok_pkg::FIFO_AW'(i_push.num);
            r_rptr  <= r_rptr + sqltok_pkg::FIFO_AW'(pop);
            r_count <= r_count + sqltok_pkg::FIFO_CW'(i_push.num)
                       - sqltok_pkg::FIFO_CW'(pop);
        end
    end

endmodule

// File: src/sql_keyword_tokenizer_unit.sv
// A token is registered into the result queue when the byte that closes it is accepted.
// Throughput: one byte per cycle; the four-entry result queue lowers s_axis_tready
// while it holds more than two tokens, so bytes that close two tokens can stall the input.
// Reset (i_rst_n low, synchronous) returns the scanner to idle at offset zero and
// empties the result queue; tokens in flight are dropped.
module sql_keyword_tokenizer_unit #(
    parameter int MAX_STRING_LEN = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] token_type, [15:4] token_start,
                                        // [28:16] token_length, [31:29] zero
    output logic        m_axis_tlast    // run_last
);

    sqltok_pkg::t_push  push;
    sqltok_pkg::t_token token;
    logic accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    sqltok_lexer #(
        .MAX_STRING_LEN(MAX_STRING_LEN)
    ) u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_char_code    (s_axis_tdata),
        .i_end_of_string(s_axis_tlast),
        .o_push         (push)
    );

    sqltok_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_space(s_axis_tready),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_token(token)
    );

    assign m_axis_tdata = {3'd0, token.token_length, token.token_start, token.token_type};
    assign m_axis_tlast = token.run_last;

endmodule

// File: src/sqltok_checker.sv
// Port-level checks of the tokenizer, bound to the top level.
module sqltok_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A result waiting for the sink keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled token changed");

    a_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd10 && m_axis_tdata[31:29] == 3'd0)
        else $error("bad token type or padding");

    // Punctuation tokens are always one byte; every token has a length.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[28:16] != 13'd0 &&
            (m_axis_tdata[3:0] < 4'd7 || m_axis_tdata[28:16] == 13'd1))
        else $error("bad token length");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("token present after reset");

endmodule

bind sql_keyword_tokenizer_unit sqltok_checker u_sqltok_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

// File: bench/tb.sv
// Self-checking bench for the SQL keyword tokenizer: byte stream in, token stream out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STRING_LIMIT = 4096;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STALL_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    sql_keyword_tokenizer_unit #(
        .MAX_STRING_LEN(STRING_LIMIT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Scanner state mirrored by the token predictor.
    logic [1:0]  scan_mode_q = sqltok_pkg::MODE_IDLE;
    int unsigned scan_pos_q = 0;
    logic [11:0] tok_start_q = '0;
    logic [47:0] word_prefix_q = '0;
    logic        word_too_long_q = 1'b0;

    sqltok_pkg::t_token step_tokens[$];
    sqltok_pkg::t_token expected_tokens[$];
    logic [7:0]  query_bytes[$];
    string       keywords[5] = '{"select", "create", "from", "drop", "int"};

    logic        idle_on = 1'b1;
    int          stall_requests = 0;
    int          stalls_served = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    function automatic logic [3:0] word_kind();
        if (word_too_long_q) return sqltok_pkg::TOK_IDENT;
        case (word_prefix_q)
            sqltok_pkg::KW_SELECT: return sqltok_pkg::TOK_SELECT;
            sqltok_pkg::KW_CREATE: return sqltok_pkg::TOK_CREATE;
            sqltok_pkg::KW_FROM:   return sqltok_pkg::TOK_FROM;
            sqltok_pkg::KW_DROP:   return sqltok_pkg::TOK_DROP;
            sqltok_pkg::KW_INT:    return sqltok_pkg::TOK_INT;
            default:               return sqltok_pkg::TOK_IDENT;
        endcase
    endfunction

    function automatic void queue_token(input logic [3:0] kind, input int unsigned start,
                                        input int unsigned len);
        sqltok_pkg::t_token t;
        t.token_type   = kind;
        t.token_start  = 12'(start);
        t.token_length = 13'(len);
        t.run_last     = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void close_open_token(input int unsigned len);
        if (scan_mode_q == sqltok_pkg::MODE_NUM) begin
            queue_token(sqltok_pkg::TOK_NUMBER, tok_start_q, len);
        end else if (scan_mode_q == sqltok_pkg::MODE_ID) begin
            queue_token(word_kind(), tok_start_q, len);
        end
        scan_mode_q = sqltok_pkg::MODE_IDLE;
    endfunction

    function automatic void clear_scanner();
        scan_mode_q     = sqltok_pkg::MODE_IDLE;
        scan_pos_q      = 0;
        tok_start_q     = '0;
        word_prefix_q   = '0;
        word_too_long_q = 1'b0;
    endfunction

    // Works out the tokens that one accepted byte releases and queues them.
    function automatic void predict_tokens(input logic [7:0] c, input logic last_char);
        int unsigned p;
        logic        is_digit;
        logic        is_lower;
        logic        is_word;
        logic        grows;
        sqltok_pkg::t_token t;
        p        = scan_pos_q;
        is_digit = c >= sqltok_pkg::CH_DIGIT_LO && c <= sqltok_pkg::CH_DIGIT_HI;
        is_lower = c >= sqltok_pkg::CH_LOWER_LO && c <= sqltok_pkg::CH_LOWER_HI;
        is_word  = is_digit || is_lower || c == sqltok_pkg::CH_UNDER;
        step_tokens.delete();
        if (p >= STRING_LIMIT) begin
            // Past the end of the allowed string only the end mark matters.
            if (last_char) begin
                close_open_token(STRING_LIMIT - tok_start_q);
                clear_scanner();
            end
        end else begin
            grows = (scan_mode_q == sqltok_pkg::MODE_NUM && is_digit) ||
                    (scan_mode_q == sqltok_pkg::MODE_ID && is_word);
            if (scan_mode_q == sqltok_pkg::MODE_ID && is_word) begin
                if (word_prefix_q[47:40] != 8'h00) word_too_long_q = 1'b1;
                else word_prefix_q = {word_prefix_q[39:0], c};
            end else if (!grows) begin
                close_open_token(p - tok_start_q);
            end
            if (!grows) begin
                if (is_digit) begin
                    scan_mode_q = sqltok_pkg::MODE_NUM;
                    tok_start_q = 12'(p);
                end else if (is_lower) begin
                    scan_mode_q     = sqltok_pkg::MODE_ID;
                    tok_start_q     = 12'(p);
                    word_prefix_q   = {40'h0, c};
                    word_too_long_q = 1'b0;
                end else begin
                    case (c)
                        sqltok_pkg::CH_PAREN_OPN: queue_token(sqltok_pkg::TOK_OPEN, p, 1);
                        sqltok_pkg::CH_PAREN_CLS: queue_token(sqltok_pkg::TOK_CLOSE, p, 1);
                        sqltok_pkg::CH_COMMA:     queue_token(sqltok_pkg::TOK_COMMA, p, 1);
                        sqltok_pkg::CH_SEMICOLON: queue_token(sqltok_pkg::TOK_SEMICOLON, p, 1);
                        default: ;
                    endcase
                end
            end
            if (last_char) begin
                close_open_token(p - tok_start_q + 1);
                clear_scanner();
            end else begin
                scan_pos_q = p + 1;
            end
        end
        foreach (step_tokens[i]) begin
            t = step_tokens[i];
            t.run_last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last_char);
        if (idle_on && $urandom_range(0, 99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last_char;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_tokens(c, last_char);
    endtask

    task automatic send_text(input string s, input logic mark_end);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], mark_end && i == s.len() - 1);
        end
    endtask

    task automatic send_query();
        foreach (query_bytes[i]) send_char(query_bytes[i], i == query_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 37);
        if (r < 26) return sqltok_pkg::CH_LOWER_LO + 8'(r);
        if (r < 36) return sqltok_pkg::CH_DIGIT_LO + 8'(r - 26);
        return sqltok_pkg::CH_UNDER;
    endfunction

    // Mostly well-formed query text, with noise bytes mixed in; send_query marks its last byte as the string end.
    function automatic void build_query();
        int    kind;
        int    count;
        int    len;
        string s;
        query_bytes.delete();
        count = $urandom_range(1, 10);
        repeat (count) begin
            kind = $urandom_range(0, 99);
            if (kind < 22) begin
                s = keywords[$urandom_range(0, 4)];
                for (int i = 0; i < s.len(); i++) query_bytes.push_back(s[i]);
                if ($urandom_range(0, 3) == 0) query_bytes.push_back(word_char());
            end else if (kind < 42) begin
                query_bytes.push_back(sqltok_pkg::CH_LOWER_LO + 8'($urandom_range(0, 25)));
                len = $urandom_range(0, 9);
                repeat (len) query_bytes.push_back(word_char());
            end else if (kind < 57) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    query_bytes.push_back(sqltok_pkg::CH_DIGIT_LO + 8'($urandom_range(0, 9)));
                end
            end else if (kind < 77) begin
                case ($urandom_range(0, 3))
                    0: query_bytes.push_back(sqltok_pkg::CH_PAREN_OPN);
                    1: query_bytes.push_back(sqltok_pkg::CH_PAREN_CLS);
                    2: query_bytes.push_back(sqltok_pkg::CH_COMMA);
                    default: query_bytes.push_back(sqltok_pkg::CH_SEMICOLON);
                endcase
            end else if (kind < 90) begin
                query_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                query_bytes.push_back($urandom_range(0, 1) ? sqltok_pkg::CH_UNDER :
                                      8'h41 + 8'($urandom_range(0, 25)));
            end
            if ($urandom_range(0, 99) < 60) query_bytes.push_back(8'h20);
        end
    endfunction

    // Receiver: random idles, plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (stalls_served != stall_requests) begin
            stall_left = STALL_CYCLES;
            stalls_served++;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 8);
        end
    end

    always @(posedge i_clk) begin : check_tokens
        sqltok_pkg::t_token want;
        sqltok_pkg::t_token got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.token_type   = m_axis_tdata[3:0];
            got.token_start  = m_axis_tdata[15:4];
            got.token_length = m_axis_tdata[28:16];
            got.run_last     = m_axis_tlast;
            if (expected_tokens.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected token: type %0d start %0d length %0d last %0b",
                             got.token_type, got.token_start, got.token_length,
                             got.run_last);
                end
                mismatches++;
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want || m_axis_tdata[31:29] !== 3'b000) begin
                    if (mismatches < 10) begin
                        $display("token mismatch: expected type %0d start %0d length %0d last %0b",
                                 want.token_type, want.token_start, want.token_length,
                                 want.run_last);
                        $display("  got type %0d start %0d length %0d last %0b pad %0h",
                                 got.token_type, got.token_start, got.token_length,
                                 got.run_last, m_axis_tdata[31:29]);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic test_keywords();
        send_text("select create from drop int", 1'b1);
    endtask

    task automatic test_words_and_numbers();
        // Too-long word, plain word, underscore word, number closed by a letter.
        send_text("selects sel a_9 0123456789x", 1'b1);
    endtask

    task automatic test_punctuation();
        // A word closed by punctuation releases two tokens from one item.
        send_text("a(b)1,c;;7", 1'b1);
    endtask

    task automatic test_skipped_bytes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("AZ_q9 @~", 1'b0);
        send_char(8'h80, 1'b1);
    endtask

    task automatic test_long_strings();
        // Word running past the position limit: length stops at the limit.
        send_char("k", 1'b0);
        for (int i = 1; i < STRING_LIMIT + 4; i++) send_char("x", i == STRING_LIMIT + 3);
        // Number opened on the last position, then bytes that are ignored.
        repeat (STRING_LIMIT - 1) send_char(8'h20, 1'b0);
        send_text("9)(5", 1'b1);
        // Nothing open when the end mark arrives past the limit.
        repeat (STRING_LIMIT + 4) send_char(8'h20, 1'b0);
        send_char(8'h20, 1'b1);
        send_text("int", 1'b1);
    endtask

    task automatic test_backpressure();
        stall_requests++;
        repeat (10) send_text("a(b)c,d;", 1'b0);
        send_text("e", 1'b1);
        wait_drained();
    endtask

    task automatic test_random_queries(input int target, input logic idling);
        int sent;
        sent    = 0;
        idle_on = idling;
        while (sent < target) begin
            build_query();
            send_query();
            sent += query_bytes.size();
            if ($urandom_range(0, 15) == 0) wait_drained();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_keywords();
        test_words_and_numbers();
        test_punctuation();
        test_skipped_bytes();
        wait_drained();
        test_long_strings();
        test_backpressure();
        test_random_queries(1500, 1'b1);
        test_random_queries(300, 1'b0);
        test_random_queries(200, 1'b1);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
